@@ sv/u8v_pkg.sv @@
// Package for the UTF-8 stream validator: byte type, byte class bounds,
// pending-continuation type. No dependencies.
package u8v_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_pend;

    localparam t_byte ASCII_HI = 8'h7f;
    localparam t_byte CONT_LO  = 8'h80;
    localparam t_byte CONT_HI  = 8'hbf;
    localparam t_byte LEAD2_LO = 8'hc0;
    localparam t_byte LEAD2_HI = 8'hdf;
    localparam t_byte LEAD3_LO = 8'he0;
    localparam t_byte LEAD3_HI = 8'hef;
    localparam t_byte LEAD4_LO = 8'hf0;
    localparam t_byte LEAD4_HI = 8'hf4;
    localparam t_byte NEWLINE  = 8'h0a;

    localparam t_pend PEND_NONE = 2'd0;
    localparam t_pend PEND_ONE  = 2'd1;
    localparam t_pend PEND_TWO  = 2'd2;
    localparam t_pend PEND_THREE = 2'd3;

endpackage

@@ sv/u8v_byte_if.sv @@
// Input channel of the UTF-8 stream validator: one stream byte per word.
// Depends on u8v_pkg.
interface u8v_byte_if
    import u8v_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

@@ sv/u8v_rslt_if.sv @@
// Result channel of the UTF-8 stream validator: status, line and column.
// No dependencies.
interface u8v_rslt_if #(
    parameter int LINE_BITS   = 32,
    parameter int COLUMN_BITS = 24
) ();
    logic                   valid;
    logic                   ready;
    logic                   status;
    logic [LINE_BITS-1:0]   line_number;
    logic [COLUMN_BITS-1:0] column_number;

    modport source (output valid, output status, output line_number,
                    output column_number, input ready);
    modport sink   (input valid, input status, input line_number,
                    input column_number, output ready);
endinterface

@@ sv/utf8_stream_validator.sv @@
// UTF-8 stream validator top level. Depends on u8v_pkg, u8v_byte_if,
// u8v_rslt_if.
//
// Takes one byte word per cycle and gives one result word at the last byte
// of each stream, or earlier at the first malformed sequence (status 1 with
// the 1-based line and lead-byte column; later bytes of that stream are
// dropped). A word passes through an input register and the classify and
// counter update logic into a result register, one word per cycle
// sustained while the result side keeps taking words. Line
// and column counters saturate at LINE_BITS and COLUMN_BITS wide.
module utf8_stream_validator
    import u8v_pkg::*;
#(
    parameter int LINE_BITS   = 32,
    parameter int COLUMN_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    u8v_byte_if.sink      i_byte,
    u8v_rslt_if.source    o_rslt
);

    localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};

    // input register
    logic  r_in_valid;
    t_byte r_byte;
    logic  r_last;

    // stream state
    t_pend                  r_pend,     n_pend;
    logic [COLUMN_BITS-1:0] r_lead_col, n_lead_col;
    logic [COLUMN_BITS-1:0] r_cur_col,  n_cur_col;
    logic [LINE_BITS-1:0]   r_line,     n_line;
    logic                   r_err,      n_err;

    // result register
    logic                   r_out_valid;
    logic                   r_status;
    logic [LINE_BITS-1:0]   r_out_line;
    logic [COLUMN_BITS-1:0] r_out_col;

    logic                   res_valid;
    logic                   res_status;
    logic [LINE_BITS-1:0]   res_line;
    logic [COLUMN_BITS-1:0] res_col;
    logic                   fail;
    logic [COLUMN_BITS-1:0] fail_col;
    logic [COLUMN_BITS-1:0] col;
    logic                   advance;

    assign advance      = r_in_valid && (!res_valid || !r_out_valid || o_rslt.ready);
    assign i_byte.ready = !r_in_valid || advance;

    always_comb begin
        n_pend     = r_pend;
        n_lead_col = r_lead_col;
        n_cur_col  = r_cur_col;
        n_line     = r_line;
        n_err      = r_err;
        fail       = 1'b0;
        fail_col   = '0;
        res_valid  = 1'b0;
        res_status = 1'b0;
        res_line   = '0;
        res_col    = '0;
        col        = (&r_cur_col) ? r_cur_col : r_cur_col + 1'b1;

        if (!r_err) begin
            if (r_pend != PEND_NONE) begin
                if (r_byte inside {[CONT_LO:CONT_HI]}) begin
                    n_pend = r_pend - 1'b1;
                end else begin
                    fail     = 1'b1;
                    fail_col = r_lead_col;
                end
            end else begin
                case (r_byte) inside
                    [8'h00:ASCII_HI]: ;
                    [LEAD2_LO:LEAD2_HI]: begin
                        n_pend     = PEND_ONE;
                        n_lead_col = col;
                    end
                    [LEAD3_LO:LEAD3_HI]: begin
                        n_pend     = PEND_TWO;
                        n_lead_col = col;
                    end
                    [LEAD4_LO:LEAD4_HI]: begin
                        n_pend     = PEND_THREE;
                        n_lead_col = col;
                    end
                    default: begin
                        fail     = 1'b1;
                        fail_col = col;
                    end
                endcase
            end

            if (!fail) begin
                if (r_byte == NEWLINE) begin
                    n_line    = (&r_line) ? r_line : r_line + 1'b1;
                    n_cur_col = '0;
                end else begin
                    n_cur_col = col;
                end
                if (r_last && n_pend != PEND_NONE) begin
                    fail     = 1'b1;
                    fail_col = n_lead_col;
                end
            end

            res_valid  = fail || r_last;
            res_status = fail;
            res_line   = fail ? r_line : '0;
            res_col    = fail ? fail_col : '0;
            n_err      = fail;
        end

        // end of stream: back to the reset state
        if (r_last) begin
            n_pend     = PEND_NONE;
            n_lead_col = '0;
            n_cur_col  = '0;
            n_line     = LINE_ONE;
            n_err      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pend      <= PEND_NONE;
            r_lead_col  <= '0;
            r_cur_col   <= '0;
            r_line      <= LINE_ONE;
            r_err       <= 1'b0;
        end else begin
            if (i_byte.valid && i_byte.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_pend     <= n_pend;
                r_lead_col <= n_lead_col;
                r_cur_col  <= n_cur_col;
                r_line     <= n_line;
                r_err      <= n_err;
            end

            if (advance && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_rslt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_byte <= i_byte.data_byte;
            r_last <= i_byte.stream_end;
        end
        if (advance && res_valid) begin
            r_status   <= res_status;
            r_out_line <= res_line;
            r_out_col  <= res_col;
        end
    end

    assign o_rslt.valid         = r_out_valid;
    assign o_rslt.status        = r_status;
    assign o_rslt.line_number   = r_out_line;
    assign o_rslt.column_number = r_out_col;

endmodule
